/* hdl/canonical_kmer_peak_extractor_defines.svh */
// Assertion macros for the checker file of the k-mer peak extractor.
`ifndef CANONICAL_KMER_PEAK_EXTRACTOR_DEFINES_SVH
`define CANONICAL_KMER_PEAK_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define CKPE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ckpe assertion failed");

// Next-cycle implication, switched off while reset is held.
`define CKPE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ckpe assertion failed");

`endif

/* hdl/ckpe_pkg.sv */
// Types and constants shared by the canonical k-mer peak extractor.
`default_nettype none

package ckpe_pkg;

    localparam int MAX_KMER_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_THRESHOLD = 4'd1;

    localparam logic [5:0]  KMER_LENGTH_RESET     = 6'd10;
    localparam logic [15:0] COUNT_THRESHOLD_RESET = 16'd200;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic [7:0]  base_char;
        logic [15:0] cut_count;
        logic        first_of_sequence;
        logic [31:0] sequence_length;
    } in_word_t;

    typedef struct packed {
        logic [31:0] window_start;
        logic [63:0] canonical_kmer;
        logic        reverse_strand;
    } out_word_t;

endpackage

`default_nettype wire

/* hdl/ckpe_track.sv */
// Input stage: base histories, valid run, position, qualify line and window hand-off.
`default_nettype none

module ckpe_track #(
    parameter int MAX_KMER   = ckpe_pkg::MAX_KMER_DEF,
    parameter int COUNT_BITS = ckpe_pkg::COUNT_BITS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  ckpe_pkg::in_word_t       s_item,
    input  wire  [5:0]               kmer_length,
    input  wire  [15:0]              count_threshold,
    input  wire                      b_ready,
    output logic                     b_valid,
    output logic [2*MAX_KMER-1:0]    b_fwd,
    output logic [2*MAX_KMER-1:0]    b_rev,
    output logic [$clog2(MAX_KMER+1)-1:0] b_k,
    output logic [31:0]              b_start
);

    localparam int WW = 2 * MAX_KMER;
    localparam int KW = $clog2(MAX_KMER + 1);
    localparam int DL = (MAX_KMER + 1) / 2;
    localparam int TW = (DL > 1) ? $clog2(DL) : 1;
    localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    logic [WW-1:0] fwd_reg, fwd_next;
    logic [WW-1:0] rev_reg, rev_next;
    logic [KW-1:0] run_reg, run_next, run_base;
    logic [31:0]   pos_reg, pos;
    logic [DL-1:0] delay_reg, delay_next, delay_base;

    logic          b_valid_reg;
    logic [WW-1:0] b_fwd_reg, b_rev_reg;
    logic [KW-1:0] b_k_reg;
    logic [31:0]   b_start_reg;

    logic [KW-1:0] k;
    logic [KW-1:0] tap;
    logic [1:0]    code;
    logic          base_ok;
    logic          qual;
    logic          emit;
    logic          accept;

    always_comb begin
        if (kmer_length == 6'd0) begin
            k = KW'(1);
        end else if (kmer_length > 6'(MAX_KMER)) begin
            k = KW'(MAX_KMER);
        end else begin
            k = kmer_length[KW-1:0];
        end
    end

    always_comb begin
        base_ok = 1'b1;
        unique case (s_item.base_char)
            ckpe_pkg::CHAR_A: code = ckpe_pkg::BASE_A;
            ckpe_pkg::CHAR_C: code = ckpe_pkg::BASE_C;
            ckpe_pkg::CHAR_G: code = ckpe_pkg::BASE_G;
            ckpe_pkg::CHAR_T: code = ckpe_pkg::BASE_T;
            default: begin
                code    = ckpe_pkg::BASE_A;
                base_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        pos        = s_item.first_of_sequence ? 32'd0 : pos_reg;
        run_base   = s_item.first_of_sequence ? '0 : run_reg;
        delay_base = s_item.first_of_sequence ? '0 : delay_reg;

        // The reverse history holds complements with the newest base at the top.
        fwd_next = (fwd_reg << 2) | WW'(code);
        rev_next = (rev_reg >> 2) | (WW'(~code) << (WW - 2));

        if (!base_ok) begin
            run_next = '0;
        end else if (run_base < KW'(MAX_KMER)) begin
            run_next = run_base + KW'(1);
        end else begin
            run_next = run_base;
        end

        qual = (16'(s_item.cut_count[CW-1:0]) > count_threshold) &&
               (pos >= 32'(k)) &&
               ((33'(pos) + 33'(k)) < 33'(s_item.sequence_length));

        delay_next = (delay_base << 1) | DL'(qual);

        // The window is centred on the qualifying base, so it looks (k-1)/2 items back.
        tap  = (k - KW'(1)) >> 1;
        emit = delay_next[tap[TW-1:0]] && (run_next >= k);
    end

    assign accept  = s_valid && s_ready;
    assign s_ready = !b_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg     <= '0;
            rev_reg     <= '0;
            run_reg     <= '0;
            pos_reg     <= '0;
            delay_reg   <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fwd_reg     <= fwd_next;
                rev_reg     <= rev_next;
                run_reg     <= run_next;
                pos_reg     <= pos + 32'd1;
                delay_reg   <= delay_next;
                b_valid_reg <= emit;
            end else if (b_ready) begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            b_fwd_reg   <= fwd_next;
            b_rev_reg   <= rev_next;
            b_k_reg     <= k;
            b_start_reg <= pos - 32'(k) + 32'd1;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_fwd   = b_fwd_reg;
    assign b_rev   = b_rev_reg;
    assign b_k     = b_k_reg;
    assign b_start = b_start_reg;

endmodule

`default_nettype wire

/* hdl/ckpe_pick.sv */
// Result stage: trims both k-mers to k bases, keeps the smaller and holds the result word.
`default_nettype none

module ckpe_pick #(
    parameter int MAX_KMER = ckpe_pkg::MAX_KMER_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      b_valid,
    output logic                     b_ready,
    input  wire  [2*MAX_KMER-1:0]    b_fwd,
    input  wire  [2*MAX_KMER-1:0]    b_rev,
    input  wire  [$clog2(MAX_KMER+1)-1:0] b_k,
    input  wire  [31:0]              b_start,
    output logic                     m_valid,
    input  wire                      m_ready,
    output ckpe_pkg::out_word_t      m_item
);

    localparam int WW = 2 * MAX_KMER;
    localparam int KW = $clog2(MAX_KMER + 1);

    logic                m_valid_reg;
    ckpe_pkg::out_word_t m_item_reg;

    logic [KW:0]   two_k;
    logic [WW-1:0] mask;
    logic [WW-1:0] fwd_m;
    logic [WW-1:0] rev_s;
    logic          pick_rev;
    logic          load;

    always_comb begin
        two_k = {b_k, 1'b0};
        if (b_k >= KW'(MAX_KMER)) begin
            mask = '1;
        end else begin
            mask = ~({WW{1'b1}} << two_k);
        end
        fwd_m    = b_fwd & mask;
        // The newest base of the reverse history sits at the top, so the window is its top 2k bits.
        rev_s    = b_rev >> ((KW + 1)'(WW) - two_k);
        pick_rev = fwd_m > rev_s;
    end

    assign b_ready = !m_valid_reg || m_ready;
    assign load    = b_valid && b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_item_reg.window_start   <= b_start;
            m_item_reg.canonical_kmer <= 64'(pick_rev ? rev_s : fwd_m);
            m_item_reg.reverse_strand <= pick_rev;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

/* hdl/canonical_kmer_peak_extractor.sv */
// Top level of the canonical k-mer peak extractor: configuration registers and the two stages.
`default_nettype none

// One base is taken per clock cycle for as long as results are drained; a result
// word passes the hand-off register, then the output register. The input
// stage updates the base histories, the valid run, the position and the qualify
// line in the cycle a word is accepted and hands any complete window to the
// result stage, which picks the smaller of the forward and reverse k-mers into
// the output register. The input side stalls only when both the hand-off
// register and the output register are full and m_ready is low. kmer_length 0
// behaves as 1 and values above MAX_KMER as MAX_KMER; registers should be written
// only while no word is in flight.
module canonical_kmer_peak_extractor #(
    parameter int MAX_KMER   = ckpe_pkg::MAX_KMER_DEF,
    parameter int COUNT_BITS = ckpe_pkg::COUNT_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  ckpe_pkg::in_word_t                  s_item,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output ckpe_pkg::out_word_t                 m_item,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [ckpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [ckpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WW = 2 * MAX_KMER;
    localparam int KW = $clog2(MAX_KMER + 1);

    logic [5:0]  kmer_length_reg;
    logic [15:0] count_threshold_reg;

    logic          b_valid;
    logic          b_ready;
    logic [WW-1:0] b_fwd;
    logic [WW-1:0] b_rev;
    logic [KW-1:0] b_k;
    logic [31:0]   b_start;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg     <= ckpe_pkg::KMER_LENGTH_RESET;
            count_threshold_reg <= ckpe_pkg::COUNT_THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ckpe_pkg::CFG_KMER_LENGTH:     kmer_length_reg     <= cfg_data[5:0];
                ckpe_pkg::CFG_COUNT_THRESHOLD: count_threshold_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ckpe_track #(
        .MAX_KMER   (MAX_KMER),
        .COUNT_BITS (COUNT_BITS)
    ) u_track (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .kmer_length     (kmer_length_reg),
        .count_threshold (count_threshold_reg),
        .b_ready         (b_ready),
        .b_valid         (b_valid),
        .b_fwd           (b_fwd),
        .b_rev           (b_rev),
        .b_k             (b_k),
        .b_start         (b_start)
    );

    ckpe_pick #(
        .MAX_KMER (MAX_KMER)
    ) u_pick (
        .aclk    (aclk),
        .aresetn (aresetn),
        .b_valid (b_valid),
        .b_ready (b_ready),
        .b_fwd   (b_fwd),
        .b_rev   (b_rev),
        .b_k     (b_k),
        .b_start (b_start),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

/* hdl/ckpe_checker.sv */
// Port-level checker for the k-mer peak extractor and its bind to the top level.
`default_nettype none

`include "canonical_kmer_peak_extractor_defines.svh"

module ckpe_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_valid,
    input wire                              s_ready,
    input wire                              m_valid,
    input wire                              m_ready,
    input ckpe_pkg::out_word_t              m_item,
    input wire                              cfg_valid,
    input wire                              cfg_ready
);

    // The input side may only stall when both result stages are full and blocked.
    `CKPE_ASSERT_IMPL(a_stall_needs_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready)

    `CKPE_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // Leaving reset the pipeline is empty and open for words.
    `CKPE_ASSERT_IMPL(a_empty_after_reset, aclk, aresetn, $rose(aresetn), !m_valid && s_ready)

    `CKPE_ASSERT_IMPL(a_cfg_never_stalls, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind canonical_kmer_peak_extractor ckpe_checker u_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the canonical k-mer peak extractor: directed table, then random genome streams.
module testbench;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int MAX_GAP       = 17;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int ROWS          = 29;
    localparam int RETUNE_ROW    = 15;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] BASE_CHARS [4] = '{ckpe_pkg::CHAR_A, ckpe_pkg::CHAR_C,
                                              ckpe_pkg::CHAR_G, ckpe_pkg::CHAR_T};

    typedef struct packed {
        ckpe_pkg::in_word_t  word;
        logic                typed;
        logic                hit;
        ckpe_pkg::out_word_t want;
    } probe_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    ckpe_pkg::in_word_t               s_item = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    ckpe_pkg::out_word_t              m_item;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ckpe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ckpe_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow of the block: registers, base histories, run length, position and qualify line.
    logic [5:0]  k_reg = ckpe_pkg::KMER_LENGTH_RESET;
    logic [15:0] thr_reg = ckpe_pkg::COUNT_THRESHOLD_RESET;
    logic [63:0] fwd_hist = '0;
    logic [63:0] rev_hist = '0;
    int unsigned run_len = 0;
    logic [31:0] next_pos = '0;
    logic [31:0] qual_line = '0;

    ckpe_pkg::out_word_t kmer_expect [$];
    int unsigned         errors = 0;
    int unsigned         rx_gap = 0;
    bit                  rx_hold = 1'b0;
    bit                  squeeze_go = 1'b0;
    bit                  calm = 1'b0;
    longint unsigned     cycles = 0;
    probe_t              probes [ROWS];

    canonical_kmer_peak_extractor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic void flag_error(input string what, input ckpe_pkg::out_word_t want,
                                       input ckpe_pkg::out_word_t got);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0s: expected start=%0d kmer=%h rev=%0b, got start=%0d kmer=%h rev=%0b",
                     what, want.window_start, want.canonical_kmer, want.reverse_strand,
                     got.window_start, got.canonical_kmer, got.reverse_strand);
    endfunction

    // Advances the shadow state by one base and returns 1 when a k-mer word is due.
    function automatic bit predict_kmer(input ckpe_pkg::in_word_t w,
                                        output ckpe_pkg::out_word_t r);
        int unsigned k;
        int unsigned tap;
        logic [1:0]  code;
        bit          good;
        bit          qual;
        logic [31:0] pos;
        logic [32:0] reach;
        logic [63:0] mask;
        logic [63:0] fwd;
        logic [63:0] rev;
        k = (k_reg == 0) ? 1 : ((k_reg > ckpe_pkg::MAX_KMER_DEF) ? ckpe_pkg::MAX_KMER_DEF
                                                                  : k_reg);
        good = 1'b1;
        case (w.base_char)
            ckpe_pkg::CHAR_A: code = ckpe_pkg::BASE_A;
            ckpe_pkg::CHAR_C: code = ckpe_pkg::BASE_C;
            ckpe_pkg::CHAR_G: code = ckpe_pkg::BASE_G;
            ckpe_pkg::CHAR_T: code = ckpe_pkg::BASE_T;
            default: begin
                code = ckpe_pkg::BASE_A;
                good = 1'b0;
            end
        endcase
        if (w.first_of_sequence) begin
            pos = '0;
            run_len = 0;
            qual_line = '0;
        end else begin
            pos = next_pos;
        end
        next_pos = pos + 32'd1;
        fwd_hist = {fwd_hist[61:0], code};
        // The complement of a 2-bit base code is its bitwise inverse.
        rev_hist = {~code, rev_hist[63:2]};
        if (!good)
            run_len = 0;
        else if (run_len < ckpe_pkg::MAX_KMER_DEF)
            run_len++;
        reach = {1'b0, pos} + k;
        qual = (w.cut_count > thr_reg) && (pos >= k) && (reach < {1'b0, w.sequence_length});
        qual_line = {qual_line[30:0], qual};
        tap = (k - 1) / 2;
        r = '0;
        if (!qual_line[tap] || run_len < k)
            return 1'b0;
        mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
        fwd = fwd_hist & mask;
        rev = rev_hist >> (64 - 2 * k);
        r.window_start = pos - (k - 1);
        if (fwd <= rev) begin
            r.canonical_kmer = fwd;
            r.reverse_strand = 1'b0;
        end else begin
            r.canonical_kmer = rev;
            r.reverse_strand = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic probe_t probe(input logic [7:0] ch, input logic [15:0] cnt,
                                     input logic first, input logic [31:0] len,
                                     input logic typed, input logic hit, input logic [31:0] ws,
                                     input logic [63:0] kmer, input logic rs);
        probe_t p;
        p.word.base_char = ch;
        p.word.cut_count = cnt;
        p.word.first_of_sequence = first;
        p.word.sequence_length = len;
        p.typed = typed;
        p.hit = hit;
        p.want.window_start = ws;
        p.want.canonical_kmer = kmer;
        p.want.reverse_strand = rs;
        return p;
    endfunction

    always @(posedge aclk) begin : check_result
        ckpe_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (kmer_expect.size() == 0) begin
                flag_error("unexpected word", '0, m_item);
            end else begin
                want = kmer_expect.pop_front();
                if (m_item.window_start !== want.window_start
                        || m_item.canonical_kmer !== want.canonical_kmer
                        || m_item.reverse_strand !== want.reverse_strand)
                    flag_error("result word", want, m_item);
            end
            rx_gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && rx_gap == 0 && !rx_hold;
        if (rx_gap != 0)
            rx_gap--;
    end

    // A long receiver stall, so that the block fills up and refuses input for a while.
    initial begin
        wait (squeeze_go);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    task automatic feed_base(input ckpe_pkg::in_word_t w, input logic typed, input logic hit,
                             input ckpe_pkg::out_word_t want);
        int unsigned         gap;
        ckpe_pkg::out_word_t got;
        bit                  made;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= w;
        do @(posedge aclk); while (!s_ready);
        made = predict_kmer(w, got);
        if (typed ? hit : made)
            kmer_expect.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    task automatic drain_results;
        s_valid <= 1'b0;
        while (kmer_expect.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [ckpe_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ckpe_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == ckpe_pkg::CFG_KMER_LENGTH)
            k_reg = val[5:0];
        else if (idx == ckpe_pkg::CFG_COUNT_THRESHOLD)
            thr_reg = val;
        @(negedge aclk);
    endtask

    task automatic retune(input logic [15:0] k_val, input logic [15:0] thr_val);
        drain_results;
        cfg_write(ckpe_pkg::CFG_KMER_LENGTH, k_val);
        cfg_write(ckpe_pkg::CFG_COUNT_THRESHOLD, thr_val);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned         ph;
        int unsigned         i;
        int unsigned         pick;
        int unsigned         seq_left;
        logic [31:0]         told_len;
        logic [7:0]          ch;
        logic [15:0]         cnt;
        bit                  first;
        bit                  dirty;
        ckpe_pkg::in_word_t  w;

        // Reset register values: one window of ten bases, centred on position ten.
        probes[0]  = probe(ckpe_pkg::CHAR_G, 16'd0, 1'b1, 32'd30, 0, 0, 0, 0, 0);
        probes[1]  = probe(ckpe_pkg::CHAR_A, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[2]  = probe(ckpe_pkg::CHAR_T, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[3]  = probe(ckpe_pkg::CHAR_T, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[4]  = probe(ckpe_pkg::CHAR_A, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[5]  = probe(ckpe_pkg::CHAR_C, 16'hFFFF, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[6]  = probe(ckpe_pkg::CHAR_A, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[7]  = probe(ckpe_pkg::CHAR_C, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[8]  = probe(ckpe_pkg::CHAR_G, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[9]  = probe(ckpe_pkg::CHAR_T, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[10] = probe(ckpe_pkg::CHAR_T, 16'd201, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[11] = probe(ckpe_pkg::CHAR_G, 16'd200, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[12] = probe(ckpe_pkg::CHAR_C, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[13] = probe(ckpe_pkg::CHAR_A, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        probes[14] = probe(ckpe_pkg::CHAR_A, 16'd0, 1'b0, 32'd30, 0, 0, 0, 0, 0);
        // A k-mer length of zero behaves as one and the threshold is zero: each base stands alone.
        probes[15] = probe(ckpe_pkg::CHAR_A, 16'd9, 1'b1, 32'd100, 1, 0, 0, 0, 0);
        probes[16] = probe(ckpe_pkg::CHAR_A, 16'd1, 1'b0, 32'd100, 1, 1, 32'd1, 64'd0, 1'b0);
        probes[17] = probe(ckpe_pkg::CHAR_C, 16'd1, 1'b0, 32'd100, 1, 1, 32'd2, 64'd1, 1'b0);
        probes[18] = probe(ckpe_pkg::CHAR_G, 16'd1, 1'b0, 32'd100, 1, 1, 32'd3, 64'd1, 1'b1);
        probes[19] = probe(ckpe_pkg::CHAR_T, 16'd1, 1'b0, 32'd100, 1, 1, 32'd4, 64'd0, 1'b1);
        probes[20] = probe(CHAR_LOWER_A, 16'd1, 1'b0, 32'd100, 1, 0, 0, 0, 0);
        probes[21] = probe(8'h00, 16'd1, 1'b0, 32'd100, 1, 0, 0, 0, 0);
        probes[22] = probe(ckpe_pkg::CHAR_A, 16'd0, 1'b0, 32'd100, 1, 0, 0, 0, 0);
        probes[23] = probe(ckpe_pkg::CHAR_A, 16'hFFFF, 1'b0, 32'd100, 1, 1, 32'd8, 64'd0, 1'b0);
        probes[24] = probe(ckpe_pkg::CHAR_C, 16'd1, 1'b0, 32'd10, 1, 0, 0, 0, 0);
        probes[25] = probe(ckpe_pkg::CHAR_C, 16'd1, 1'b0, 32'd12, 1, 1, 32'd10, 64'd1, 1'b0);
        probes[26] = probe(8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1, 0, 0, 0, 0);
        probes[27] = probe(ckpe_pkg::CHAR_T, 16'd1, 1'b0, 32'hFFFF_FFFF, 1, 1, 32'd1, 64'd0,
                           1'b1);
        probes[28] = probe(ckpe_pkg::CHAR_G, 16'd1, 1'b0, 32'd0, 1, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < ROWS; i++) begin
            if (i == RETUNE_ROW)
                retune(16'd0, 16'd0);
            feed_base(probes[i].word, probes[i].typed, probes[i].hit, probes[i].want);
        end

        seq_left = 0;
        told_len = '0;
        dirty = 1'b0;
        first = 1'b0;
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: retune(16'd32, 16'd0);
                1: retune(16'd63, 16'd1000);
                2: retune(16'd1, 16'hFFFF);
                3: retune(16'(ckpe_pkg::KMER_LENGTH_RESET), ckpe_pkg::COUNT_THRESHOLD_RESET);
                4: retune(16'd5, 16'd100);
                5: retune(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4095)));
                6: retune(16'd0, 16'd30000);
                default: retune(16'd17, 16'($urandom_range(0, 65535)));
            endcase
            calm = (ph % 3 == 2);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 4 && i == 20)
                    squeeze_go = 1'b1;
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    drain_results;
                // Now and then a sequence is cut short by the start of the next one.
                if (seq_left == 0 || $urandom_range(0, 199) == 0) begin
                    seq_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 400)
                                                           : $urandom_range(1, 140);
                    told_len = seq_left;
                    pick = $urandom_range(0, 19);
                    if (pick < 2)
                        told_len = $urandom;
                    else if (pick == 2)
                        told_len = $urandom_range(0, 3);
                    dirty = ($urandom_range(0, 9) < 3);
                    first = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < (dirty ? 10 : 1))
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = BASE_CHARS[$urandom_range(0, 3)];
                pick = $urandom_range(0, 9);
                if (pick < 6 && thr_reg != 16'hFFFF)
                    cnt = 16'($urandom_range(thr_reg + 1, 65535));
                else if (pick < 8)
                    cnt = 16'($urandom_range(0, 65535));
                else if (pick == 8)
                    cnt = thr_reg;
                else
                    cnt = 16'($urandom_range(0, thr_reg));
                w.base_char = ch;
                w.cut_count = cnt;
                w.first_of_sequence = first;
                w.sequence_length = ($urandom_range(0, 49) == 0) ? $urandom : told_len;
                feed_base(w, 1'b0, 1'b0, '0);
                first = 1'b0;
                seq_left--;
            end
        end

        drain_results;
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
